// ----- src/assert_macros.svh -----
// Assertion macros used by the decoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- src/lzwd_pkg.sv -----
// Shared types and constants of the LZW decoder
package lzwd_pkg;
  localparam int DICT_ENTRIES_DEF   = 65536;
  localparam int MAX_CODE_WIDTH_DEF = 16;
  localparam int MAX_STRING_DEF     = 512;

  localparam logic [16:0] CODE_END   = 17'h100;
  localparam logic [16:0] CODE_WIDEN = 17'h101;
  localparam logic [16:0] CODE_CLEAR = 17'h102;
  localparam logic [16:0] CODE_FIRST = 17'h103;
  localparam logic [4:0]  WIDTH_INIT = 5'd9;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXTRACT, ST_CODE, ST_WALK, ST_WAIT, ST_PUSHLAST,
    ST_POP, ST_POPWAIT, ST_FLUSH, ST_POST, ST_STATUS, ST_FINAL
  } state_t;
endpackage

// ----- src/lzwd_ram.sv -----
// Generic single-port-write, registered-read RAM
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- src/lzw_variable_width_decoder_core.sv -----
// Top level of the variable-width LZW decoder
// Takes one compressed byte at a time; ready only in idle.
// The dictionary read port and the stack pop set the pace.
// Reset: synchronous active-low rst_n clears stream state; limit goes to all ones.
// Dictionary and stack contents are not cleared.
`include "assert_macros.svh"
module lzw_variable_width_decoder_core import lzwd_pkg::*; #(
  parameter int DICT_ENTRIES   = DICT_ENTRIES_DEF,
  parameter int MAX_CODE_WIDTH = MAX_CODE_WIDTH_DEF,
  parameter int MAX_STRING     = MAX_STRING_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        in_new_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_last,
  output logic        out_done_res,
  output logic        out_error,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  localparam int DAW = $clog2(DICT_ENTRIES);
  localparam int SAW = $clog2(MAX_STRING);
  localparam int LW  = SAW + 1;

  state_t state_r, state_nxt;
  logic [31:0] limit_r;
  logic [23:0] res_r, res_nxt;
  logic [4:0]  cnt_r, cnt_nxt, cw_r, cw_nxt;
  logic [16:0] nc_r, nc_nxt, code_r, code_nxt;
  logic [15:0] prev_r, prev_nxt, cur_r, cur_nxt;
  logic [7:0]  pfb_r, pfb_nxt;
  logic        lit_r, lit_nxt, stop_r, stop_nxt, lastin_r, lastin_nxt;
  logic [31:0] emit_r, emit_nxt;
  logic [LW-1:0] len_r, len_nxt, npop_r, npop_nxt;
  logic [63:0] word_r, word_nxt;
  logic [3:0]  wc_r, wc_nxt;
  logic        err_r, err_nxt, any_r, any_nxt;
  // output register
  logic        ov_r, ov_nxt;
  logic [63:0] ob_r, ob_nxt;
  logic [3:0]  oc_r, oc_nxt;
  logic        ol_r, ol_nxt, od_r, od_nxt, oe_r, oe_nxt;
  // held result waiting for a successor, so flags can land on it
  logic        hv_r, hv_nxt;
  logic [63:0] hb_r, hb_nxt;
  logic [3:0]  hc_r, hc_nxt;
  logic        hd_r, hd_nxt, he_r, he_nxt;

  logic          d_we, s_we;
  logic [DAW-1:0] d_waddr, d_raddr;
  logic [23:0]   d_wdata, d_rdata;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [7:0]    s_wdata, s_rdata;

  lzwd_ram #(.WIDTH(24), .DEPTH(DICT_ENTRIES)) u_dict (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata));
  lzwd_ram #(.WIDTH(8), .DEPTH(MAX_STRING)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata));

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = ov_r;
  assign out_bytes      = ob_r;
  assign out_byte_count = oc_r;
  assign out_last       = ol_r;
  assign out_done_res   = od_r;
  assign out_error      = oe_r;

  logic [16:0] mask;
  logic [31:0] room;
  logic [LW-1:0] n_emit;
  logic        ofree;

  // Next state and datapath control
  always_comb begin
    state_nxt = state_r; res_nxt = res_r; cnt_nxt = cnt_r; cw_nxt = cw_r;
    nc_nxt = nc_r; code_nxt = code_r; prev_nxt = prev_r; cur_nxt = cur_r;
    pfb_nxt = pfb_r; lit_nxt = lit_r; stop_nxt = stop_r; lastin_nxt = lastin_r;
    emit_nxt = emit_r; len_nxt = len_r; npop_nxt = npop_r; word_nxt = word_r;
    wc_nxt = wc_r; err_nxt = err_r; any_nxt = any_r;
    ov_nxt = ov_r; ob_nxt = ob_r; oc_nxt = oc_r; ol_nxt = ol_r; od_nxt = od_r;
    oe_nxt = oe_r;
    hv_nxt = hv_r; hb_nxt = hb_r; hc_nxt = hc_r; hd_nxt = hd_r; he_nxt = he_r;
    d_we = 1'b0; d_waddr = nc_r[DAW-1:0];
    d_wdata = {prev_r, cur_r[7:0]};
    d_raddr = cur_r[DAW-1:0];
    s_we = 1'b0; s_waddr = len_r[SAW-1:0]; s_wdata = 8'd0;
    s_raddr = npop_r[SAW-1:0] - 1'b1;
    mask = (17'd1 << cw_r) - 17'd1;
    room = limit_r - emit_r;
    n_emit = ({{(32-LW){1'b0}}, len_r} > room) ? room[LW-1:0] : len_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    ofree = !ov_r || out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_new_stream) begin
            res_nxt = '0; cnt_nxt = '0; cw_nxt = WIDTH_INIT; nc_nxt = CODE_FIRST;
            prev_nxt = '0; pfb_nxt = '0; lit_nxt = 1'b1; emit_nxt = '0;
            stop_nxt = 1'b0;
          end
          if (!stop_r || in_new_stream) begin
            res_nxt = (in_new_stream ? 24'd0 : res_r)
                    | (24'(in_byte) << (in_new_stream ? 5'd0 : cnt_r));
            cnt_nxt = (in_new_stream ? 5'd0 : cnt_r) + 5'd8;
            lastin_nxt = in_last; any_nxt = 1'b0;
            state_nxt = ST_EXTRACT;
          end
        end
      end
      ST_EXTRACT: begin
        if (!stop_r && cnt_r >= cw_r) begin
          code_nxt = {1'b0, res_r[15:0]} & mask;
          res_nxt = res_r >> cw_r;
          cnt_nxt = cnt_r - cw_r;
          // any_r tracks results of the current code only
          any_nxt = 1'b0;
          state_nxt = ST_CODE;
        end else if (!stop_r && lastin_r) begin
          // final byte: flags go on any result of this beat
          err_nxt = 1'b0; any_nxt = 1'b1; state_nxt = ST_STATUS;
        end else begin
          state_nxt = ST_FINAL;
        end
      end
      ST_CODE: begin
        err_nxt = 1'b0; len_nxt = '0;
        if (emit_r >= limit_r) begin
          state_nxt = ST_STATUS;
        end else if (lit_r) begin
          s_we = 1'b1; s_waddr = '0; s_wdata = code_r[7:0];
          len_nxt = LW'(1); npop_nxt = LW'(1);
          prev_nxt = code_r[15:0]; pfb_nxt = code_r[7:0]; lit_nxt = 1'b0;
          word_nxt = '0; wc_nxt = '0;
          emit_nxt = emit_r + 32'd1;
          state_nxt = ST_POPWAIT;
        end else if (code_r == CODE_END) begin
          state_nxt = ST_STATUS;
        end else if (code_r == CODE_WIDEN) begin
          if (cw_r >= 5'(MAX_CODE_WIDTH)) begin
            err_nxt = 1'b1; state_nxt = ST_STATUS;
          end else begin
            cw_nxt = cw_r + 5'd1; state_nxt = ST_EXTRACT;
          end
        end else if (code_r == CODE_CLEAR) begin
          lit_nxt = 1'b1; cw_nxt = WIDTH_INIT; nc_nxt = CODE_FIRST;
          state_nxt = ST_EXTRACT;
        end else begin
          cur_nxt = code_r[15:0];
          if (code_r >= nc_r) begin
            s_we = 1'b1; s_waddr = '0; s_wdata = pfb_r;
            len_nxt = LW'(1); cur_nxt = prev_r;
          end
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cur_r > 16'hFF) begin
          if (len_r >= LW'(MAX_STRING)) begin
            err_nxt = 1'b1; state_nxt = ST_STATUS;
          end else begin
            state_nxt = ST_WAIT;
          end
        end else if (len_r >= LW'(MAX_STRING)) begin
          err_nxt = 1'b1; state_nxt = ST_STATUS;
        end else begin
          state_nxt = ST_PUSHLAST;
        end
      end
      ST_WAIT: begin
        // d_rdata valid for cur_r
        if (32'(cur_r) < DICT_ENTRIES) begin
          s_we = 1'b1; s_wdata = d_rdata[7:0]; cur_nxt = d_rdata[23:8];
        end else begin
          s_we = 1'b1; s_wdata = 8'd0; cur_nxt = '0;
        end
        len_nxt = len_r + 1'b1;
        state_nxt = ST_WALK;
      end
      ST_PUSHLAST: begin
        s_we = 1'b1; s_wdata = cur_r[7:0];
        len_nxt = len_r + 1'b1;
        state_nxt = ST_POST;
      end
      ST_POST: begin
        // emit count, dictionary update
        npop_nxt = n_emit; word_nxt = '0; wc_nxt = '0;
        emit_nxt = emit_r + 32'(n_emit);
        if ({15'd0, nc_r} >= DICT_ENTRIES) begin
          err_nxt = 1'b1;
        end else begin
          d_we = 1'b1; nc_nxt = nc_r + 17'd1;
        end
        prev_nxt = code_r[15:0]; pfb_nxt = cur_r[7:0];
        len_nxt = len_r;
        // pop from top: index len-1 downward; store remaining count
        npop_nxt = n_emit;
        len_nxt = len_r;
        state_nxt = (n_emit == '0) ? ST_FLUSH : ST_POPWAIT;
      end
      ST_POPWAIT: begin
        // read the current top of the stack
        s_raddr = SAW'(len_r - 1'b1);
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (ofree || wc_r != 4'd7 && npop_r != LW'(1)) begin
          word_nxt = word_r | (64'(s_rdata) << {wc_r[2:0], 3'd0});
          if (wc_r == 4'd7 || npop_r == LW'(1)) begin
            // move held result out, new word becomes held
            if (hv_r) begin
              ov_nxt = 1'b1; ob_nxt = hb_r; oc_nxt = hc_r; ol_nxt = 1'b0;
              od_nxt = hd_r; oe_nxt = he_r;
            end
            hv_nxt = 1'b1; hb_nxt = word_r | (64'(s_rdata) << {wc_r[2:0], 3'd0});
            hc_nxt = wc_r + 4'd1; hd_nxt = 1'b0; he_nxt = 1'b0; any_nxt = 1'b1;
            word_nxt = '0; wc_nxt = '0;
          end else begin
            wc_nxt = wc_r + 4'd1;
          end
          len_nxt = len_r - 1'b1;
          npop_nxt = npop_r - 1'b1;
          state_nxt = (npop_r == LW'(1)) ? ST_FLUSH : ST_POPWAIT;
        end
      end
      ST_FLUSH: begin
        if (err_r || emit_r >= limit_r) state_nxt = ST_STATUS;
        else state_nxt = ST_EXTRACT;
      end
      ST_STATUS: begin
        // end of decoding: flag last result of this code, or add status beat
        stop_nxt = 1'b1;
        if (hv_r && any_r) begin
          hd_nxt = 1'b1; he_nxt = hd_r ? he_r : err_r;
          if (!(hd_r)) he_nxt = he_r | err_r;
          state_nxt = ST_FINAL;
        end else if (ofree) begin
          // push an earlier held result out ahead of the status beat
          if (hv_r) begin
            ov_nxt = 1'b1; ob_nxt = hb_r; oc_nxt = hc_r; ol_nxt = 1'b0;
            od_nxt = hd_r; oe_nxt = he_r;
          end
          hv_nxt = 1'b1; hb_nxt = '0; hc_nxt = '0; hd_nxt = 1'b1; he_nxt = err_r;
          any_nxt = 1'b1; state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        // flush held result as last beat of this byte
        if (hv_r) begin
          if (ofree) begin
            ov_nxt = 1'b1; ob_nxt = hb_r; oc_nxt = hc_r; ol_nxt = 1'b1;
            od_nxt = hd_r; oe_nxt = he_r; hv_nxt = 1'b0; state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; limit_r <= '1; res_r <= '0; cnt_r <= '0;
      cw_r <= WIDTH_INIT; nc_r <= CODE_FIRST; prev_r <= '0; pfb_r <= '0;
      lit_r <= 1'b1; emit_r <= '0; stop_r <= 1'b0; ov_r <= 1'b0; hv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      limit_r <= cfg_we ? cfg_wdata : limit_r;
      res_r <= res_nxt; cnt_r <= cnt_nxt; cw_r <= cw_nxt; nc_r <= nc_nxt;
      prev_r <= prev_nxt; pfb_r <= pfb_nxt; lit_r <= lit_nxt; emit_r <= emit_nxt;
      stop_r <= stop_nxt; ov_r <= ov_nxt; hv_r <= hv_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    code_r <= code_nxt; cur_r <= cur_nxt; lastin_r <= lastin_nxt;
    len_r <= len_nxt; npop_r <= npop_nxt; word_r <= word_nxt; wc_r <= wc_nxt;
    err_r <= err_nxt; any_r <= any_nxt;
    ob_r <= ob_nxt; oc_r <= oc_nxt; ol_r <= ol_nxt; od_r <= od_nxt; oe_r <= oe_nxt;
    hb_r <= hb_nxt; hc_r <= hc_nxt; hd_r <= hd_nxt; he_r <= he_nxt;
  end

  `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > 5'd24)
  `ASSERT_NEVER(a_cw_range, clk, rst_n, cw_r < WIDTH_INIT || cw_r > 5'(MAX_CODE_WIDTH))
  `ASSERT_NEVER(a_err_done, clk, rst_n, ov_r && oe_r && !od_r)
  `ASSERT_IMPL(a_cnt_word, clk, rst_n, (ov_r && oc_r > 4'd8) |-> 1'b0)
endmodule
